@@ rtl/zstg_pkg.sv @@
`timescale 1ns / 1ps

package zstg_pkg;

    // Default map store depth (words per chip)
    localparam int MAP_WORDS_DEF = 8192;

    // Queue depths
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    // Input word kinds
    localparam logic KIND_MAP    = 1'b0;
    localparam logic KIND_SPRITE = 1'b1;

    // Attribute word fields
    localparam int ORIGIN_BITS = 9;
    localparam logic [15:0] ENABLE_MASK = 16'h0080;
    localparam logic [15:0] PRIO_MASK   = 16'h0010;

    // Zoom curve, indexed by the top nibble of the origin words
    localparam logic [5:0] ZOOM_CURVE [16] = '{
        6'd0, 6'd7, 6'd14, 6'd20, 6'd25, 6'd30, 6'd34, 6'd38,
        6'd42, 6'd46, 6'd49, 6'd52, 6'd54, 6'd57, 6'd59, 6'd61
    };

    // Command word passed from the front to the sequencer
    typedef struct packed {
        logic        kind;
        logic        chip;
        logic [12:0] map_addr;
        logic [15:0] map_data;
        logic [8:0]  org_x;
        logic [8:0]  org_y;
        logic [4:0]  zoom_x;
        logic [4:0]  zoom_y;
        logic [3:0]  colour;
        logic        behind;
        logic        flip_x;
        logic        flip_y;
        logic [2:0]  wsz;
        logic [2:0]  hsz;
        logic [1:0]  skip;
        logic [15:0] start_idx;
    } cmd_t;

    // Tile command word as it leaves the block
    typedef struct packed {
        logic [15:0] tile_code;
        logic        gfx_chip;
        logic [5:0]  colour;
        logic        flip_x;
        logic        flip_y;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [4:0]  zoom_x;
        logic [4:0]  zoom_y;
        logic        behind;
        logic        last;
    } tile_t;

    // Tile step in pixels for one zoom index
    function automatic logic [4:0] zoom_step(logic [3:0] sel);
        logic [5:0] curve;
        curve = ZOOM_CURVE[sel];
        return 5'd16 - {2'b00, curve[5:3]};
    endfunction

    // Extra map words skipped at the end of each row
    function automatic logic [1:0] row_skip(logic [2:0] wsz);
        logic [1:0] s;
        unique case (wsz)
            3'd2:    s = 2'd1;
            3'd4:    s = 2'd3;
            3'd5:    s = 2'd2;
            3'd6:    s = 2'd1;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

    // 9-bit wrapped screen position minus 16, as a 10-bit pattern
    function automatic logic [9:0] screen_pos(logic [8:0] origin, logic [4:0] step,
                                              logic [2:0] k);
        logic [7:0] prod;
        logic [8:0] p;
        prod = 8'(step) * 8'(k);
        p    = origin + {1'b0, prod} + 9'd16;
        return {1'b0, p} - 10'd16;
    endfunction

endpackage

@@ rtl/zstg_fifo.sv @@
`timescale 1ns / 1ps

module zstg_fifo #(
    parameter int DEPTH = zstg_pkg::CMD_DEPTH,
    parameter type item_t = zstg_pkg::cmd_t
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  item_t                      wdata,
    output logic                       full,
    input  logic                       pop,
    output item_t                      rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  level_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  level_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (level_reg == CW'(DEPTH));
    assign empty   = (level_reg == '0);
    assign level   = level_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/zstg_front.sv @@
`timescale 1ns / 1ps

module zstg_front (
    input  logic             push,
    output logic             full,
    input  logic             kind,
    input  logic             chip,
    input  logic [12:0]      map_addr,
    input  logic [15:0]      map_data,
    input  logic [15:0]      attr_word0,
    input  logic [15:0]      attr_word1,
    input  logic [15:0]      attr_word2,
    input  logic [15:0]      attr_word3,
    output logic             cmd_push,
    output zstg_pkg::cmd_t   cmd_word,
    input  logic             cmd_full
);

    logic enabled;

    // Drop sprites whose enable bit is clear; map writes always go through
    assign enabled  = (kind == zstg_pkg::KIND_MAP) ||
                      ((attr_word2 & zstg_pkg::ENABLE_MASK) != 16'h0000);
    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full && enabled;

    // Decode the attribute words into a command word
    always_comb
    begin
        cmd_word.kind      = kind;
        cmd_word.chip      = chip;
        cmd_word.map_addr  = map_addr;
        cmd_word.map_data  = map_data;
        cmd_word.org_y     = attr_word0[zstg_pkg::ORIGIN_BITS-1:0];
        cmd_word.org_x     = attr_word1[zstg_pkg::ORIGIN_BITS-1:0];
        cmd_word.zoom_y    = zstg_pkg::zoom_step(attr_word0[15:12]);
        cmd_word.zoom_x    = zstg_pkg::zoom_step(attr_word1[15:12]);
        cmd_word.colour    = attr_word2[3:0];
        cmd_word.behind    = ((attr_word2 & zstg_pkg::PRIO_MASK) == 16'h0000);
        cmd_word.wsz       = attr_word2[10:8];
        cmd_word.flip_x    = attr_word2[11];
        cmd_word.hsz       = attr_word2[14:12];
        cmd_word.flip_y    = attr_word2[15];
        cmd_word.skip      = zstg_pkg::row_skip(attr_word2[10:8]);
        cmd_word.start_idx = attr_word3;
    end

endmodule

@@ rtl/zstg_back.sv @@
`timescale 1ns / 1ps

module zstg_back #(
    parameter int MAP_WORDS = zstg_pkg::MAP_WORDS_DEF,
    parameter int OUT_DEPTH = zstg_pkg::OUT_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_data,
    input  logic                           cmd_empty,
    input  zstg_pkg::cmd_t                 cmd_word,
    output logic                           cmd_pop,
    output logic                           tile_push,
    output zstg_pkg::tile_t                tile_word,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level
);

    localparam int AW = $clog2(MAP_WORDS);
    localparam int LW = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    zstg_pkg::cmd_t   spr_reg;
    zstg_pkg::cmd_t   spr_next;
    logic [2:0]       row_reg;
    logic [2:0]       row_next;
    logic [2:0]       col_reg;
    logic [2:0]       col_next;
    logic [15:0]      idx_reg;
    logic [15:0]      idx_next;
    logic [1:0]       pal_reg;
    logic             valid_b_reg;
    zstg_pkg::tile_t  meta_b_reg;
    zstg_pkg::tile_t  meta_b_next;
    logic [15:0]      rd0_reg;
    logic [15:0]      rd1_reg;
    logic [15:0]      store0 [MAP_WORDS];
    logic [15:0]      store1 [MAP_WORDS];
    logic             issue;
    logic             last_tile;
    logic             mem_we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [2:0]       kx;
    logic [2:0]       ky;
    logic [LW:0]      used;

    // Room check: waiting words plus the one in flight
    assign used      = {1'b0, out_level} + {{LW{1'b0}}, valid_b_reg};
    assign issue     = (state_reg == ST_RUN) && (used < (LW + 1)'(OUT_DEPTH));
    assign last_tile = (row_reg == spr_reg.hsz) && (col_reg == spr_reg.wsz);
    assign kx        = spr_reg.flip_x ? (spr_reg.wsz - col_reg) : col_reg;
    assign ky        = spr_reg.flip_y ? (spr_reg.hsz - row_reg) : row_reg;
    assign raddr     = idx_reg[AW-1:0];
    assign waddr     = AW'(cmd_word.map_addr);
    assign mem_we    = (state_reg == ST_IDLE) && !cmd_empty &&
                       (cmd_word.kind == zstg_pkg::KIND_MAP);

    // Sequence the tiles of one sprite
    always_comb
    begin
        state_next = state_reg;
        spr_next   = spr_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        idx_next   = idx_reg;
        cmd_pop    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_word.kind == zstg_pkg::KIND_SPRITE)
                    begin
                        spr_next   = cmd_word;
                        row_next   = 3'd0;
                        col_next   = 3'd0;
                        idx_next   = cmd_word.start_idx;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    if (col_reg == spr_reg.wsz)
                    begin
                        col_next = 3'd0;
                        row_next = row_reg + 3'd1;
                        idx_next = idx_reg + 16'd1 + {14'd0, spr_reg.skip};
                        if (row_reg == spr_reg.hsz)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 3'd1;
                        idx_next = idx_reg + 16'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Build the tile fields alongside the map read
    always_comb
    begin
        meta_b_next.tile_code = 16'h0000;
        meta_b_next.gfx_chip  = spr_reg.chip;
        meta_b_next.colour    = {pal_reg, spr_reg.colour};
        meta_b_next.flip_x    = spr_reg.flip_x;
        meta_b_next.flip_y    = spr_reg.flip_y;
        meta_b_next.pos_x     = zstg_pkg::screen_pos(spr_reg.org_x, spr_reg.zoom_x, kx);
        meta_b_next.pos_y     = zstg_pkg::screen_pos(spr_reg.org_y, spr_reg.zoom_y, ky);
        meta_b_next.zoom_x    = spr_reg.zoom_x;
        meta_b_next.zoom_y    = spr_reg.zoom_y;
        meta_b_next.behind    = spr_reg.behind;
        meta_b_next.last      = last_tile;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_b_reg <= 1'b0;
            pal_reg     <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_b_reg <= issue;
            if (cfg_we)
            begin
                pal_reg <= cfg_data;
            end
        end
    end

    // Hold sprite walk and stage fields
    always_ff @(posedge clk)
    begin
        spr_reg <= spr_next;
        row_reg <= row_next;
        col_reg <= col_next;
        idx_reg <= idx_next;
        if (issue)
        begin
            meta_b_reg <= meta_b_next;
        end
    end

    // Map store for chip zero
    always_ff @(posedge clk)
    begin
        if (mem_we && !cmd_word.chip)
        begin
            store0[waddr] <= cmd_word.map_data;
        end
        if (issue)
        begin
            rd0_reg <= store0[raddr];
        end
    end

    // Map store for chip one
    always_ff @(posedge clk)
    begin
        if (mem_we && cmd_word.chip)
        begin
            store1[waddr] <= cmd_word.map_data;
        end
        if (issue)
        begin
            rd1_reg <= store1[raddr];
        end
    end

    // Merge the read word into the outgoing tile
    always_comb
    begin
        tile_word           = meta_b_reg;
        tile_word.tile_code = meta_b_reg.gfx_chip ? rd1_reg : rd0_reg;
    end
    assign tile_push = valid_b_reg;

    // The output queue never receives a word it has no room for
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        valid_b_reg |-> (out_level < LW'(OUT_DEPTH)))
        else $error("tile pushed into a full output queue");

    // The final tile of a sprite returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && last_tile) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not stop after the last tile");

    // The tile walk stays inside the sprite grid
    a_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> ((row_reg <= spr_reg.hsz) && (col_reg <= spr_reg.wsz)))
        else $error("tile walk left the sprite grid");

    // Map writes never overlap a sprite walk
    a_no_write_run: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> !mem_we)
        else $error("map write during tile reads");

endmodule

@@ rtl/zoomed_sprite_tile_generator.sv @@
`timescale 1ns / 1ps
// Zoomed sprite tile generator.
// Input queue side: push/full with kind, chip, map_addr, map_data and four
// attribute words. A map word (kind 0) is written into the map store of the
// chosen chip; a sprite word (kind 1) with its enable bit set expands into
// one tile command per tile, rows outer and columns inner; a disabled sprite
// is consumed and gives nothing.
// Result queue side: empty/pop; the oldest tile command sits on the result
// ports while empty is low. last marks the final tile of each sprite.
// Configuration: cfg_valid/cfg_ready/cfg_data writes the palette bank; ready
// is always high. Write it only while the block is idle.
// Flow: a front decoder feeds a two-word command queue; the tile sequencer
// behind it issues one map read per cycle while the result queue has room,
// and a map write is taken by the idle sequencer from the command queue. A
// sprite word passes the command queue, the sequencer load and a registered
// map read before its first tile enters the result queue.
// A full result queue stalls the sequencer; the command queue then fills and
// full rises. Reset empties both queues and clears the palette bank; the map
// stores keep no reset value and must be written before they are read.
module zoomed_sprite_tile_generator #(
    parameter int MAP_WORDS = zstg_pkg::MAP_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              kind,
    input  logic              chip,
    input  logic [12:0]       map_addr,
    input  logic [15:0]       map_data,
    input  logic [15:0]       attr_word0,
    input  logic [15:0]       attr_word1,
    input  logic [15:0]       attr_word2,
    input  logic [15:0]       attr_word3,
    output logic              empty,
    input  logic              pop,
    output logic [15:0]       tile_code,
    output logic              gfx_chip,
    output logic [5:0]        colour,
    output logic              flip_x,
    output logic              flip_y,
    output logic signed [9:0] pos_x,
    output logic signed [9:0] pos_y,
    output logic [4:0]        zoom_x,
    output logic [4:0]        zoom_y,
    output logic              behind_tiles,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data
);

    localparam int CLW = $clog2(zstg_pkg::CMD_DEPTH + 1);
    localparam int OLW = $clog2(zstg_pkg::OUT_DEPTH + 1);

    logic             cmd_push;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    zstg_pkg::cmd_t   cmd_in;
    zstg_pkg::cmd_t   cmd_out;
    logic [CLW-1:0]   cmd_level;
    logic             tile_push;
    logic             tile_full;
    zstg_pkg::tile_t  tile_in;
    zstg_pkg::tile_t  tile_out;
    logic [OLW-1:0]   out_level;

    assign cfg_ready = 1'b1;

    // Decode and classify incoming words
    zstg_front u_front (
        .push       (push),
        .full       (full),
        .kind       (kind),
        .chip       (chip),
        .map_addr   (map_addr),
        .map_data   (map_data),
        .attr_word0 (attr_word0),
        .attr_word1 (attr_word1),
        .attr_word2 (attr_word2),
        .attr_word3 (attr_word3),
        .cmd_push   (cmd_push),
        .cmd_word   (cmd_in),
        .cmd_full   (cmd_full)
    );

    // Command queue between front and sequencer
    zstg_fifo #(
        .DEPTH  (zstg_pkg::CMD_DEPTH),
        .item_t (zstg_pkg::cmd_t)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty),
        .level (cmd_level)
    );

    // Tile sequencer with map stores
    zstg_back #(
        .MAP_WORDS (MAP_WORDS),
        .OUT_DEPTH (zstg_pkg::OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_empty (cmd_empty),
        .cmd_word  (cmd_out),
        .cmd_pop   (cmd_pop),
        .tile_push (tile_push),
        .tile_word (tile_in),
        .out_level (out_level)
    );

    // Result queue
    zstg_fifo #(
        .DEPTH  (zstg_pkg::OUT_DEPTH),
        .item_t (zstg_pkg::tile_t)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tile_push),
        .wdata (tile_in),
        .full  (tile_full),
        .pop   (pop),
        .rdata (tile_out),
        .empty (empty),
        .level (out_level)
    );

    assign tile_code    = tile_out.tile_code;
    assign gfx_chip     = tile_out.gfx_chip;
    assign colour       = tile_out.colour;
    assign flip_x       = tile_out.flip_x;
    assign flip_y       = tile_out.flip_y;
    assign pos_x        = $signed(tile_out.pos_x);
    assign pos_y        = $signed(tile_out.pos_y);
    assign zoom_x       = tile_out.zoom_x;
    assign zoom_y       = tile_out.zoom_y;
    assign behind_tiles = tile_out.behind;
    assign last         = tile_out.last;

    // The sequencer pushes only with room, so the result queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        tile_push |-> !tile_full)
        else $error("result queue overflow");

    // Command queue level stays within its depth
    a_cmd_level: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_level <= CLW'(zstg_pkg::CMD_DEPTH))
        else $error("command queue level out of range");

    // A popped command leaves the queue non-full next cycle when nothing arrives
    a_cmd_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && !cmd_push) |=> !cmd_full)
        else $error("command queue did not drain");

endmodule
